[sv/modbus_rtu_slave_frame_engine_core_assert.svh]
// Assertion macros for the Modbus RTU slave frame engine.
`ifndef MODBUS_RTU_SLAVE_FRAME_ENGINE_CORE_ASSERT_SVH
`define MODBUS_RTU_SLAVE_FRAME_ENGINE_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define MRS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication checked in the cycle after the antecedent.
`define MRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[sv/mrs_pkg.sv]
// Shared types and constants for the Modbus RTU slave frame engine.
package mrs_pkg;
  localparam int unsigned NumRegsDefault    = 64;
  localparam int unsigned MaxReadRegsDefault = 16;
  localparam logic [15:0] CrcInit  = 16'hFFFF;
  localparam logic [15:0] CrcPoly  = 16'hA001;
  localparam logic [7:0]  AddrReset = 8'h01;
  localparam logic [7:0]  FuncRead  = 8'd3;
  localparam logic [7:0]  FuncWrite = 8'd6;
  localparam int unsigned FrameLen  = 8;

  // Byte source for the output register.
  typedef enum logic [1:0] {
    SRC_STORE = 2'd0,
    SRC_REG   = 2'd1,
    SRC_CRC   = 2'd2,
    SRC_CNT   = 2'd3
  } src_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic       absorb;     // take rx byte into store, count, start crc
    logic       crc_step;   // one crc bit step
    logic       frame_clr;  // reset count and crc
    logic       tx_crc_clr; // reset response crc
    logic       tx_crc_load;// xor byte into response crc
    logic       tx_crc_step;
    logic       reg_wr;
    logic       reg_rd;     // not read by the datapath, which reads the register file at the read pointer
    logic       ptr_init;
    logic       ptr_inc;
    logic       out_load;
    src_e       src;
    logic [2:0] idx;        // store index or crc byte select
    logic       hi;         // register half
    logic       last;
  } cmd_t;

  // Datapath status for the controller.
  typedef struct packed {
    logic frame_ok;
    logic is_read;
    logic read_ok;
    logic is_write;
    logic write_ok;
    logic out_busy;
    logic qty_done;
  } sts_t;

  function automatic logic [15:0] crc_bit(input logic [15:0] c);
    crc_bit = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
  endfunction
endpackage

[sv/mrs_datapath.sv]
// Datapath: frame store, bit-serial CRCs, register file and output register.
module mrs_datapath #(
  parameter int unsigned NUM_REGS      = mrs_pkg::NumRegsDefault,
  parameter int unsigned MAX_READ_REGS = mrs_pkg::MaxReadRegsDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [7:0]     rx_byte_i,
  input  logic [7:0]     slave_address_i,
  input  mrs_pkg::cmd_t  cmd_i,
  output mrs_pkg::sts_t  sts_o,
  input  logic           tx_ready_i,
  output logic           tx_valid_o,
  output logic [7:0]     tx_byte_o,
  output logic           tx_last_o
);
  localparam int unsigned AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  logic [7:0]  store_q [mrs_pkg::FrameLen];
  logic [7:0]  cnt_q;
  logic [15:0] crc_q, tcrc_q;
  logic [15:0] mem [NUM_REGS];
  logic [NUM_REGS-1:0] vld_q;
  logic [15:0] rd_q;
  logic        rd_vld_q;
  logic [AW-1:0] ptr_q;
  logic [15:0] left_q;
  logic        tv_q;
  logic [7:0]  tb_q;
  logic        tl_q;
  logic [15:0] a_w, q_w, rdata;
  logic [7:0]  obyte;

  assign a_w = {store_q[2], store_q[3]};
  assign q_w = {store_q[4], store_q[5]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.absorb && cnt_q < 8'(mrs_pkg::FrameLen)) begin
      store_q[cnt_q[2:0]] <= rx_byte_i;
    end
    if (cmd_i.reg_wr) begin
      mem[a_w[AW-1:0]] <= q_w;
    end
    rd_q <= mem[ptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      crc_q    <= mrs_pkg::CrcInit;
      tcrc_q   <= mrs_pkg::CrcInit;
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      ptr_q    <= '0;
      left_q   <= '0;
      tv_q     <= 1'b0;
      tb_q     <= '0;
      tl_q     <= 1'b0;
    end else begin
      if (cmd_i.frame_clr) begin
        cnt_q <= '0;
        crc_q <= mrs_pkg::CrcInit;
      end else if (cmd_i.absorb) begin
        if (cnt_q != 8'hFF) cnt_q <= cnt_q + 8'd1;
        crc_q <= crc_q ^ {8'h00, rx_byte_i};
      end else if (cmd_i.crc_step) begin
        crc_q <= mrs_pkg::crc_bit(crc_q);
      end
      if (cmd_i.tx_crc_clr) tcrc_q <= mrs_pkg::CrcInit;
      else if (cmd_i.tx_crc_load) tcrc_q <= tcrc_q ^ {8'h00, obyte};
      else if (cmd_i.tx_crc_step) tcrc_q <= mrs_pkg::crc_bit(tcrc_q);
      if (cmd_i.reg_wr) vld_q[a_w[AW-1:0]] <= 1'b1;
      rd_vld_q <= vld_q[ptr_q];
      if (cmd_i.ptr_init) begin
        ptr_q  <= a_w[AW-1:0];
        left_q <= q_w;
      end else if (cmd_i.ptr_inc) begin
        ptr_q  <= ptr_q + AW'(1);
        left_q <= left_q - 16'd1;
      end
      if (cmd_i.out_load) begin
        tv_q <= 1'b1;
        tb_q <= obyte;
        tl_q <= cmd_i.last;
      end else if (tv_q && tx_ready_i) begin
        tv_q <= 1'b0;
      end
    end
  end

  assign rdata = rd_vld_q ? rd_q : 16'h0000;

  always_comb begin
    case (cmd_i.src)
      mrs_pkg::SRC_STORE: obyte = store_q[cmd_i.idx];
      mrs_pkg::SRC_REG:   obyte = cmd_i.hi ? rdata[15:8] : rdata[7:0];
      mrs_pkg::SRC_CRC:   obyte = cmd_i.idx[0] ? tcrc_q[15:8] : tcrc_q[7:0];
      mrs_pkg::SRC_CNT:   obyte = {q_w[6:0], 1'b0};
      default:            obyte = store_q[cmd_i.idx];
    endcase
  end

  always_comb begin
    sts_o.frame_ok = (cnt_q == 8'(mrs_pkg::FrameLen)) && (crc_q == 16'h0000) &&
                     (store_q[0] == slave_address_i);
    sts_o.is_read  = (store_q[1] == mrs_pkg::FuncRead);
    sts_o.is_write = (store_q[1] == mrs_pkg::FuncWrite);
    sts_o.read_ok  = (q_w != 16'd0) && (q_w <= 16'(MAX_READ_REGS)) &&
                     ({1'b0, a_w} + {1'b0, q_w} <= 17'(NUM_REGS));
    sts_o.write_ok = ({1'b0, a_w} < 17'(NUM_REGS));
    sts_o.out_busy = tv_q && !tx_ready_i;
    sts_o.qty_done = (left_q == 16'd0);
  end

  assign tx_valid_o = tv_q;
  assign tx_byte_o  = tb_q;
  assign tx_last_o  = tl_q;
endmodule

[sv/mrs_ctrl.sv]
// Controller: receive sequencing and response byte scheduling.
module mrs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rx_valid_i,
  input  logic          frame_end_i,
  output logic          rx_ready_o,
  output mrs_pkg::cmd_t cmd_o,
  input  mrs_pkg::sts_t sts_i,
  output logic          idle_o
);
  typedef enum logic [3:0] {
    S_IDLE, S_CRC, S_CHECK, S_ECHO, S_RHDR, S_RADDR, S_RWAIT, S_RBYTE,
    S_CRCLOAD, S_CRCBIT, S_TCRC
  } state_e;

  typedef enum logic [1:0] { N_HDR, N_HI, N_LO } next_e;

  state_e     state_q;
  logic [2:0] bit_q, idx_q;
  logic       end_q;
  next_e      nxt_q;
  logic       hi_q;

  assign rx_ready_o = (state_q == S_IDLE);
  assign idle_o     = (state_q == S_IDLE);

  always_comb begin
    cmd_o = '0;
    cmd_o.src = mrs_pkg::SRC_STORE;
    cmd_o.idx = idx_q;
    cmd_o.hi  = hi_q;
    case (state_q)
      S_IDLE:  cmd_o.absorb = rx_valid_i;
      S_CRC:   cmd_o.crc_step = 1'b1;
      S_CHECK: begin
        cmd_o.frame_clr = 1'b1;
        cmd_o.reg_wr = sts_i.frame_ok && sts_i.is_write && sts_i.write_ok;
        cmd_o.ptr_init = 1'b1;
        cmd_o.tx_crc_clr = 1'b1;
      end
      S_ECHO: begin
        cmd_o.out_load = !sts_i.out_busy;
        cmd_o.last = (idx_q == 3'd7);
      end
      S_RHDR: begin
        cmd_o.src = (idx_q == 3'd2) ? mrs_pkg::SRC_CNT : mrs_pkg::SRC_STORE;
        cmd_o.out_load = !sts_i.out_busy;
        cmd_o.tx_crc_load = !sts_i.out_busy;
      end
      S_RBYTE: begin
        cmd_o.src = mrs_pkg::SRC_REG;
        cmd_o.out_load = !sts_i.out_busy;
        cmd_o.tx_crc_load = !sts_i.out_busy;
        cmd_o.ptr_inc = !sts_i.out_busy && !hi_q;
      end
      S_CRCBIT: cmd_o.tx_crc_step = 1'b1;
      S_TCRC: begin
        cmd_o.src = mrs_pkg::SRC_CRC;
        cmd_o.out_load = !sts_i.out_busy;
        cmd_o.last = idx_q[0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      bit_q   <= '0;
      idx_q   <= '0;
      end_q   <= 1'b0;
      nxt_q   <= N_HDR;
      hi_q    <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: if (rx_valid_i) begin
          end_q   <= frame_end_i;
          bit_q   <= '0;
          state_q <= S_CRC;
        end
        S_CRC: begin
          bit_q <= bit_q + 3'd1;
          if (bit_q == 3'd7) state_q <= end_q ? S_CHECK : S_IDLE;
        end
        S_CHECK: begin
          idx_q <= '0;
          if (!sts_i.frame_ok) state_q <= S_IDLE;
          else if (sts_i.is_write && sts_i.write_ok) state_q <= S_ECHO;
          else if (sts_i.is_read && sts_i.read_ok) state_q <= S_RHDR;
          else state_q <= S_IDLE;
        end
        S_ECHO: if (!sts_i.out_busy) begin
          idx_q <= idx_q + 3'd1;
          if (idx_q == 3'd7) state_q <= S_IDLE;
        end
        S_RHDR: if (!sts_i.out_busy) begin
          idx_q   <= idx_q + 3'd1;
          nxt_q   <= (idx_q == 3'd2) ? N_HI : N_HDR;
          bit_q   <= '0;
          state_q <= S_CRCBIT;
        end
        S_RADDR: state_q <= S_RWAIT;
        S_RWAIT: begin
          hi_q    <= 1'b1;
          state_q <= S_RBYTE;
        end
        S_RBYTE: if (!sts_i.out_busy) begin
          nxt_q   <= hi_q ? N_LO : N_HI;
          hi_q    <= 1'b0;
          bit_q   <= '0;
          state_q <= S_CRCBIT;
        end
        S_CRCBIT: begin
          bit_q <= bit_q + 3'd1;
          if (bit_q == 3'd7) begin
            case (nxt_q)
              N_HDR: state_q <= S_RHDR;
              N_LO:  state_q <= S_RBYTE;
              N_HI: begin
                if (sts_i.qty_done) begin
                  idx_q   <= '0;
                  state_q <= S_TCRC;
                end else begin
                  state_q <= S_RADDR;
                end
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_TCRC: if (!sts_i.out_busy) begin
          idx_q <= idx_q + 3'd1;
          if (idx_q[0]) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

[sv/modbus_rtu_slave_frame_engine_core.sv]
// Top level of the Modbus RTU slave frame engine.
// Usage:
//  rx channel (rx_valid_i/rx_ready_o) takes one request byte per item with
//  frame_end_i on the final byte. Each byte takes a load step and then
//  eight bit-serial steps of the request CRC shifter; the next byte waits.
//  At frame end a check state decides: a good function 6 frame writes the
//  register and echoes 8 bytes; a good function 3 frame returns the header,
//  the registers high byte first and the CRC low byte first.
//  The first response item is loaded into the output register once the CRC
//  steps and the check state for the last request byte have run.
//  Response items leave on tx_valid_o/tx_ready_o through an output register.
//  Read header and register bytes are each loaded and followed by eight
//  response CRC steps; high bytes follow the S_RADDR/S_RWAIT read states.
//  The two CRC bytes and echo bytes leave one per cycle unless stalled.
//  No request byte is taken while a response is running. A stalled receiver
//  holds the output register and the sequencer waits on it.
//  cfg channel writes slave_address; always ready; reset value 1.
//  Reset clears the register file (valid bits), the byte count and the CRC;
//  no clearing pass is needed.
module modbus_rtu_slave_frame_engine_core #(
  parameter int unsigned NUM_REGS      = mrs_pkg::NumRegsDefault,
  parameter int unsigned MAX_READ_REGS = mrs_pkg::MaxReadRegsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  output logic       rx_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       frame_end_i,
  output logic       tx_valid_o,
  input  logic       tx_ready_i,
  output logic [7:0] tx_byte_o,
  output logic       tx_last_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);
  `include "modbus_rtu_slave_frame_engine_core_assert.svh"

  logic [7:0]    addr_q;
  mrs_pkg::cmd_t cmd;
  mrs_pkg::sts_t sts;
  logic          idle;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= mrs_pkg::AddrReset;
    end else if (cfg_valid_i) begin
      addr_q <= cfg_data_i;
    end
  end

  mrs_ctrl u_ctrl (
    .clk_i, .rst_ni, .rx_valid_i, .frame_end_i, .rx_ready_o,
    .cmd_o(cmd), .sts_i(sts), .idle_o(idle)
  );

  mrs_datapath #(.NUM_REGS(NUM_REGS), .MAX_READ_REGS(MAX_READ_REGS)) u_dp (
    .clk_i, .rst_ni, .rx_byte_i, .slave_address_i(addr_q),
    .cmd_i(cmd), .sts_o(sts), .tx_ready_i, .tx_valid_o, .tx_byte_o, .tx_last_o
  );

  `MRS_ASSERT_IMPL(a_no_load_when_busy, clk_i, rst_ni, cmd.out_load, !sts.out_busy,
    "output register overwritten while stalled")
  `MRS_ASSERT_IMPL(a_absorb_idle, clk_i, rst_ni, cmd.absorb, idle,
    "byte absorbed outside idle")
  `MRS_ASSERT_NEXT(a_rx_then_busy, clk_i, rst_ni, rx_valid_i && rx_ready_o, !rx_ready_o,
    "request byte taken twice")
endmodule

[tb/sv/tb_mrs_checker.sv]
// Response predictor and scoreboard for the Modbus RTU slave frame engine.
module tb_mrs_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  input  logic       rx_ready_i,
  input  logic [7:0] rx_byte_i,
  input  logic       frame_end_i,
  input  logic       tx_valid_i,
  input  logic       tx_ready_i,
  input  logic [7:0] tx_byte_i,
  input  logic       tx_last_i,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic [7:0] cfg_data_i,
  output int         err_count_o,
  output int         pending_o,
  output int         checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } tx_item_t;

  tx_item_t    resp_q[$];
  logic [15:0] reg_file [mrs_pkg::NumRegsDefault];
  logic [7:0]  frame_buf [mrs_pkg::FrameLen];
  logic [7:0]  rx_count;
  logic [15:0] rx_crc;
  logic [7:0]  slave_addr;

  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ mrs_pkg::CrcPoly) : (r >> 1);
    return r;
  endfunction

  // Absorb one request byte; queue the response bytes it triggers.
  task automatic frame_engine_step(input logic [7:0] b, input logic fend);
    bit          ok;
    int unsigned a, q;
    logic [15:0] c, r;
    logic [7:0]  hdr [3];
    if (rx_count < mrs_pkg::FrameLen) frame_buf[rx_count] = b;
    if (rx_count != 8'hFF) rx_count++;
    rx_crc = crc16_byte(rx_crc, b);
    if (!fend) return;
    ok = (rx_count == mrs_pkg::FrameLen) && (rx_crc == 16'h0000) &&
         (frame_buf[0] == slave_addr);
    rx_count = '0;
    rx_crc   = mrs_pkg::CrcInit;
    if (!ok) return;
    a = {frame_buf[2], frame_buf[3]};
    q = {frame_buf[4], frame_buf[5]};
    if (frame_buf[1] == mrs_pkg::FuncRead) begin
      if (q < 1 || q > mrs_pkg::MaxReadRegsDefault || a + q > mrs_pkg::NumRegsDefault) return;
      hdr[0] = frame_buf[0];
      hdr[1] = frame_buf[1];
      hdr[2] = 8'(q * 2);
      c = mrs_pkg::CrcInit;
      for (int i = 0; i < 3; i++) begin
        resp_q.push_back('{hdr[i], 1'b0});
        c = crc16_byte(c, hdr[i]);
      end
      for (int unsigned i = 0; i < q; i++) begin
        r = reg_file[a + i];
        resp_q.push_back('{r[15:8], 1'b0});
        c = crc16_byte(c, r[15:8]);
        resp_q.push_back('{r[7:0], 1'b0});
        c = crc16_byte(c, r[7:0]);
      end
      resp_q.push_back('{c[7:0], 1'b0});
      resp_q.push_back('{c[15:8], 1'b1});
    end else if (frame_buf[1] == mrs_pkg::FuncWrite) begin
      if (a >= mrs_pkg::NumRegsDefault) return;
      reg_file[a] = q[15:0];
      for (int i = 0; i < mrs_pkg::FrameLen; i++)
        resp_q.push_back('{frame_buf[i], i == mrs_pkg::FrameLen - 1});
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tx_item_t exp_item;
    if (!rst_ni) begin
      foreach (reg_file[i]) reg_file[i] = '0;
      foreach (frame_buf[i]) frame_buf[i] = '0;
      rx_count    = '0;
      rx_crc      = mrs_pkg::CrcInit;
      slave_addr  = mrs_pkg::AddrReset;
      resp_q.delete();
      err_count_o = 0;
      checked_o   = 0;
    end else begin
      if (tx_valid_i && tx_ready_i) begin
        if (resp_q.size() == 0) begin
          err_count_o++;
          $display("%0t: unexpected response byte: expected none, actual byte %02h last %0b",
                   $time, tx_byte_i, tx_last_i);
        end else begin
          exp_item = resp_q.pop_front();
          checked_o++;
          if (tx_byte_i !== exp_item.data) begin
            err_count_o++;
            $display("%0t: tx_byte mismatch: expected %02h, actual %02h",
                     $time, exp_item.data, tx_byte_i);
          end
          if (tx_last_i !== exp_item.last) begin
            err_count_o++;
            $display("%0t: tx_last mismatch: expected %0b, actual %0b",
                     $time, exp_item.last, tx_last_i);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) slave_addr = cfg_data_i;
      if (rx_valid_i && rx_ready_i) frame_engine_step(rx_byte_i, frame_end_i);
    end
    pending_o = resp_q.size();
  end
endmodule

[tb/sv/tb_top.sv]
// Stimulus, flow control and verdict for the Modbus RTU slave frame engine test.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] FuncWriteMulti = 8'd16;
  localparam int         DrainCycles    = 60;
  localparam int         HoldCycles     = 400;
  localparam int         ItemsTarget    = 110;

  typedef logic [7:0] byte_q_t[$];

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       rx_valid = 1'b0;
  logic [7:0] rx_byte = '0;
  logic       rx_end = 1'b0;
  logic       tx_ready = 1'b0;
  logic       cfg_valid = 1'b0;
  logic [7:0] cfg_data = '0;
  logic       rx_ready, tx_valid, tx_last, cfg_ready;
  logic [7:0] tx_byte;
  int         err_count, pending, checked;

  bit         gaps_on = 1'b1;
  bit         hold_go = 1'b0;
  logic [7:0] cur_addr = mrs_pkg::AddrReset;
  int         bytes_sent = 0;
  int         frames_sent = 0;

  always #1 clk = ~clk;

  modbus_rtu_slave_frame_engine_core uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .rx_valid_i (rx_valid),
    .rx_ready_o (rx_ready),
    .rx_byte_i  (rx_byte),
    .frame_end_i(rx_end),
    .tx_valid_o (tx_valid),
    .tx_ready_i (tx_ready),
    .tx_byte_o  (tx_byte),
    .tx_last_o  (tx_last),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  tb_mrs_checker chk (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .rx_valid_i (rx_valid),
    .rx_ready_i (rx_ready),
    .rx_byte_i  (rx_byte),
    .frame_end_i(rx_end),
    .tx_valid_i (tx_valid),
    .tx_ready_i (tx_ready),
    .tx_byte_i  (tx_byte),
    .tx_last_i  (tx_last),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_i(cfg_ready),
    .cfg_data_i (cfg_data),
    .err_count_o(err_count),
    .pending_o  (pending),
    .checked_o  (checked)
  );

  // Response side: random stalls, plus one long hold-off on request.
  initial begin
    bit seen_go;
    seen_go = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go != seen_go) begin
        seen_go = hold_go;
        tx_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      tx_ready <= !(gaps_on && $urandom_range(99) < 33);
    end
  end

  initial begin
    #2000000;
    $display("modbus_rtu_slave_frame_engine_core test failed");
    $finish;
  end

  function automatic logic [15:0] frame_crc(input byte_q_t f);
    logic [15:0] c;
    c = mrs_pkg::CrcInit;
    foreach (f[i]) begin
      c ^= {8'h00, f[i]};
      for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ mrs_pkg::CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic byte_q_t req(input logic [7:0] addr, input logic [7:0] fn,
                                  input logic [15:0] a, input logic [15:0] v);
    byte_q_t f;
    f = '{addr, fn, a[15:8], a[7:0], v[15:8], v[7:0]};
    return f;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fend);
    while (gaps_on && $urandom_range(99) < 33) begin
      rx_valid <= 1'b0;
      @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    rx_end   <= fend;
    @(posedge clk);
    while (!rx_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Send bytes as they are, frame end on the last one.
  task automatic send_raw(input byte_q_t f);
    foreach (f[i]) send_byte(f[i], i == f.size() - 1);
    frames_sent++;
  endtask

  // Append the CRC, low byte first; optionally corrupt it.
  task automatic send_frame(input byte_q_t f, input bit good_crc);
    logic [15:0] c;
    c = frame_crc(f);
    if (!good_crc) c ^= 16'(1 << $urandom_range(15));
    f.push_back(c[7:0]);
    f.push_back(c[15:8]);
    send_raw(f);
  endtask

  // Drop valid, wait for every response, then let a rejected frame finish.
  task automatic drain();
    rx_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_addr(input logic [7:0] addr);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= addr;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_addr = addr;
  endtask

  task automatic send_random_frame();
    byte_q_t     f;
    int unsigned pick, q;
    logic [7:0]  fn, addr;
    logic [15:0] a;
    pick = $urandom_range(99);
    if (pick < 25) begin
      // noise: random length and content
      repeat ($urandom_range(1, 10)) f.push_back(8'($urandom));
      send_raw(f);
      return;
    end
    addr = ($urandom_range(9) == 0) ? 8'($urandom) : cur_addr;
    pick = $urandom_range(99);
    if (pick < 45) begin
      fn = mrs_pkg::FuncRead;
      q  = ($urandom_range(9) == 0) ? $urandom_range(0, 17) : $urandom_range(1, 4);
      a  = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 64 - 1));
      if (q >= 1 && q <= 16 && $urandom_range(3) != 0) a = 16'($urandom_range(0, 64 - q));
      f  = req(addr, fn, a, 16'(q));
    end else if (pick < 85) begin
      fn = mrs_pkg::FuncWrite;
      a  = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 63));
      f  = req(addr, fn, a, 16'($urandom));
    end else begin
      fn = ($urandom_range(1) != 0) ? FuncWriteMulti : 8'($urandom);
      f  = req(addr, fn, 16'($urandom), 16'($urandom));
    end
    send_frame(f, $urandom_range(9) != 0);
  endtask

  initial begin
    byte_q_t f;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset address, reads and writes at the register-file edges.
    send_frame(req(mrs_pkg::AddrReset, mrs_pkg::FuncRead, 16'd0, 16'd1), 1'b1);
    send_frame(req(mrs_pkg::AddrReset, mrs_pkg::FuncWrite, 16'd0, 16'hFFFF), 1'b1);
    send_frame(req(mrs_pkg::AddrReset, mrs_pkg::FuncWrite, 16'd63, 16'h8001), 1'b1);
    send_frame(req(mrs_pkg::AddrReset, mrs_pkg::FuncWrite, 16'd48, 16'h00FF), 1'b1);
    // hold the receiver off while full-size reads pile up
    hold_go = ~hold_go;
    send_frame(req(mrs_pkg::AddrReset, mrs_pkg::FuncRead, 16'd48, 16'd16), 1'b1);
    send_frame(req(mrs_pkg::AddrReset, mrs_pkg::FuncRead, 16'd0, 16'd16), 1'b1);
    send_frame(req(mrs_pkg::AddrReset, mrs_pkg::FuncRead, 16'd0, 16'd17), 1'b1);
    send_frame(req(mrs_pkg::AddrReset, mrs_pkg::FuncRead, 16'd60, 16'd5), 1'b1);
    send_frame(req(mrs_pkg::AddrReset, mrs_pkg::FuncWrite, 16'd64, 16'h1234), 1'b1);
    send_frame(req(mrs_pkg::AddrReset, mrs_pkg::FuncWrite, 16'd1, 16'h5555), 1'b0);
    f = req(mrs_pkg::AddrReset, mrs_pkg::FuncRead, 16'd0, 16'd1);
    send_raw(f);

    // A read and random frames under station address 247, then random frames under the reset address.
    write_addr(8'd247);
    send_frame(req(8'd247, mrs_pkg::FuncRead, 16'd62, 16'd2), 1'b1);
    gaps_on = 1'b0;
    repeat (2) send_random_frame();
    gaps_on = 1'b1;
    write_addr(mrs_pkg::AddrReset);
    while (bytes_sent < ItemsTarget) send_random_frame();

    drain();
    $display("Sent %0d frames (%0d bytes) over several station addresses; %0d response bytes checked.",
             frames_sent, bytes_sent, checked);
    if (err_count == 0) begin
      $display("modbus_rtu_slave_frame_engine_core test passed");
    end else begin
      $display("modbus_rtu_slave_frame_engine_core test failed");
    end
    $finish;
  end
endmodule

[files.f]
+incdir+sv
sv/mrs_pkg.sv
sv/mrs_datapath.sv
sv/mrs_ctrl.sv
sv/modbus_rtu_slave_frame_engine_core.sv
tb/sv/tb_mrs_checker.sv
tb/sv/tb_top.sv
